// ===== rtl/core/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants of the sorted table interpolating lookup unit.
// ----------------------------------------------------------------------------
package sti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 64;

   localparam int COUNT_W     = 11;
   localparam int INDEX_W     = 10;
   localparam int WORD_W      = 32;

   localparam int DIVIDEND_W  = 64;
   localparam int DIV_STEPS   = DIVIDEND_W / 2;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_VALUE  = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   typedef struct packed {
      logic                     kind;
      logic [INDEX_W-1:0]       entry_index;
      logic [WORD_W-1:0]        entry_time;
      logic signed [WORD_W-1:0] entry_value;
      logic [WORD_W-1:0]        query_time;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] result_value;
   } rsp_type;

endpackage

// ===== rtl/core/sti_ram.sv =====
// ----------------------------------------------------------------------------
// sti_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sti_div.sv =====
// ----------------------------------------------------------------------------
// sti_div
// Unsigned 64 by 32 bit restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sti_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sti_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [sti_pkg::WORD_W-1:0]       divisor,
   output logic                             done,
   output logic [sti_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sti_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [sti_pkg::DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [sti_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [sti_pkg::WORD_W-1:0]     rem_ff, rem_in;
   logic [sti_pkg::WORD_W-1:0]     dsr_ff, dsr_in;

   logic [sti_pkg::WORD_W:0]       t1, t2;
   logic [sti_pkg::WORD_W-1:0]     r1, r2;
   logic                           b1, b2;

   always_comb begin
      t1 = {rem_ff, dvd_ff[sti_pkg::DIVIDEND_W-1]};
      b1 = (t1 >= {1'b0, dsr_ff});
      r1 = b1 ? sti_pkg::WORD_W'(t1 - {1'b0, dsr_ff}) : t1[sti_pkg::WORD_W-1:0];
      t2 = {r1, dvd_ff[sti_pkg::DIVIDEND_W-2]};
      b2 = (t2 >= {1'b0, dsr_ff});
      r2 = b2 ? sti_pkg::WORD_W'(t2 - {1'b0, dsr_ff}) : t2[sti_pkg::WORD_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = sti_pkg::STEP_W'(sti_pkg::DIV_STEPS - 1);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[sti_pkg::DIVIDEND_W-3:0], 2'b00};
         quo_in = {quo_ff[sti_pkg::DIVIDEND_W-3:0], b1, b2};
         rem_in = r2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/sorted_table_interpolating_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_interpolating_lookup_unit
// Sorted (time, value) table with binary search and linear interpolation.
// ----------------------------------------------------------------------------
// A load request writes one table point. A query reads the first and last
// points in use and checks the range, then runs binary search probes
// (about log2 of the entry count, 9 or 10 at 1024 entries, fewer on an
// exact hit), then does the final compare. A query that needs
// interpolation then goes through a multiply and the divider, which
// retires two quotient bits per cycle. The table sits in one RAM with a
// registered read, read once per search step. One request is worked at a
// time; a finished response waits in its output register while the next
// request is taken. Table entries are undefined until loaded.
module sorted_table_interpolating_lookup_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sti_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sti_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [sti_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int AW = sti_pkg::ADDR_W;
   localparam int W  = sti_pkg::WORD_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FIRST   = 4'd1;
   localparam logic [3:0] S_LAST    = 4'd2;
   localparam logic [3:0] S_PROBE   = 4'd3;
   localparam logic [3:0] S_CHECK   = 4'd4;
   localparam logic [3:0] S_MUL     = 4'd5;
   localparam logic [3:0] S_DSTART  = 4'd6;
   localparam logic [3:0] S_DWAIT   = 4'd7;
   localparam logic [3:0] S_FINAL   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [sti_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sti_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   sti_pkg::rsp_type            res_ff, res_in;

   logic [W-1:0]                q_ff, q_in;
   logic [AW-1:0]               lo_ff, lo_in;
   logic [AW-1:0]               hi_ff, hi_in;
   logic [AW-1:0]               mid_ff, mid_in;
   logic [W-1:0]                t_lo_ff, t_lo_in;
   logic [W-1:0]                v_lo_ff, v_lo_in;
   logic [W-1:0]                t_hi_ff, t_hi_in;
   logic [W-1:0]                v_hi_ff, v_hi_in;
   logic [W-1:0]                mv_ff, mv_in;
   logic [W-1:0]                mq_ff, mq_in;
   logic [W-1:0]                mt_ff, mt_in;
   logic                        neg_ff, neg_in;
   logic [2*W-1:0]              prod_ff, prod_in;
   logic [W+1:0]                mag_ff, mag_in;

   logic                        accept;
   logic                        out_free;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [AW-1:0]               ram_rd_addr;
   logic [sti_pkg::ENTRY_W-1:0] ram_rd_data;
   logic [W-1:0]                rd_time;
   logic [W-1:0]                rd_value;

   logic                        div_start;
   logic                        div_done;
   logic [sti_pkg::DIVIDEND_W-1:0] div_quo;

   logic [31:0]                 n_use;
   logic [AW-1:0]               nlo, nhi;
   logic [AW:0]                 msum;
   logic signed [W:0]           dv, dq, dt;
   logic signed [W+2:0]         inc;
   logic signed [W+2:0]         sum;

   assign rd_time  = ram_rd_data[sti_pkg::ENTRY_W-1:W];
   assign rd_value = ram_rd_data[W-1:0];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_wr_en = accept && (req_data.kind == sti_pkg::KIND_LOAD)
                      && (32'(req_data.entry_index) < sti_pkg::TABLE_DEPTH);
   assign ram_wr_addr = AW'(req_data.entry_index);

   sti_ram #(
      .WIDTH (sti_pkg::ENTRY_W),
      .DEPTH (sti_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_data.entry_time, req_data.entry_value}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      q_in         = q_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      t_lo_in      = t_lo_ff;
      v_lo_in      = v_lo_ff;
      t_hi_in      = t_hi_ff;
      v_hi_in      = v_hi_ff;
      mv_in        = mv_ff;
      mq_in        = mq_ff;
      mt_in        = mt_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      ram_rd_addr  = '0;
      div_start    = 1'b0;

      n_use = 32'(count_ff);
      if (n_use < 32'd2) begin
         n_use = 32'd2;
      end
      if (n_use > sti_pkg::TABLE_DEPTH) begin
         n_use = sti_pkg::TABLE_DEPTH;
      end

      nlo  = lo_ff;
      nhi  = hi_ff;
      msum = '0;

      dv  = $signed({v_hi_ff[W-1], v_hi_ff}) - $signed({v_lo_ff[W-1], v_lo_ff});
      dq  = $signed({1'b0, q_ff}) - $signed({1'b0, t_lo_ff});
      dt  = $signed({1'b0, t_hi_ff}) - $signed({1'b0, t_lo_ff});
      inc = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      sum = $signed({{3{v_lo_ff[W-1]}}, v_lo_ff}) + inc;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.kind == sti_pkg::KIND_LOAD) begin
                  res_in.status       = sti_pkg::STATUS_LOADED;
                  res_in.result_value = '0;
                  state_in            = S_DONE;
               end else begin
                  q_in        = req_data.query_time;
                  lo_in       = '0;
                  hi_in       = AW'(n_use - 32'd1);
                  ram_rd_addr = '0;
                  state_in    = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            t_lo_in     = rd_time;
            v_lo_in     = rd_value;
            ram_rd_addr = hi_ff;
            state_in    = S_LAST;
         end
         S_LAST: begin
            t_hi_in = rd_time;
            v_hi_in = rd_value;
            msum    = {1'b0, lo_ff} + {1'b0, hi_ff};
            if ((q_ff < t_lo_ff) || (q_ff > rd_time)) begin
               res_in.status       = sti_pkg::STATUS_RANGE;
               res_in.result_value = '0;
               state_in            = S_DONE;
            end else if ((hi_ff - lo_ff) > AW'(1)) begin
               mid_in      = msum[AW:1];
               ram_rd_addr = msum[AW:1];
               state_in    = S_PROBE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_PROBE: begin
            if (rd_time == q_ff) begin
               res_in.status       = sti_pkg::STATUS_VALUE;
               res_in.result_value = rd_value;
               state_in            = S_DONE;
            end else begin
               if (rd_time > q_ff) begin
                  nhi     = mid_ff;
                  t_hi_in = rd_time;
                  v_hi_in = rd_value;
               end else begin
                  nlo     = mid_ff;
                  t_lo_in = rd_time;
                  v_lo_in = rd_value;
               end
               lo_in = nlo;
               hi_in = nhi;
               msum  = {1'b0, nlo} + {1'b0, nhi};
               if ((nhi - nlo) > AW'(1)) begin
                  mid_in      = msum[AW:1];
                  ram_rd_addr = msum[AW:1];
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            mv_in  = dv[W] ? W'(-dv) : dv[W-1:0];
            mq_in  = dq[W] ? W'(-dq) : dq[W-1:0];
            mt_in  = dt[W] ? W'(-dt) : dt[W-1:0];
            neg_in = dv[W] ^ dq[W] ^ dt[W];
            res_in.status = sti_pkg::STATUS_VALUE;
            if (t_lo_ff == q_ff) begin
               res_in.result_value = v_lo_ff;
               state_in            = S_DONE;
            end else if (t_hi_ff == q_ff) begin
               res_in.result_value = v_hi_ff;
               state_in            = S_DONE;
            end else if (dt == '0) begin
               res_in.result_value = v_lo_ff;
               state_in            = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mv_ff * mq_ff;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               if (div_quo > sti_pkg::DIVIDEND_W'(64'h2_0000_0000)) begin
                  mag_in = (W+2)'(64'h2_0000_0000);
               end else begin
                  mag_in = div_quo[W+1:0];
               end
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            res_in.status = sti_pkg::STATUS_VALUE;
            if (sum > $signed((W+3)'(32'h7FFF_FFFF))) begin
               res_in.result_value = {1'b0, {(W-1){1'b1}}};
            end else if (sum < -$signed((W+3)'(33'h0_8000_0000))) begin
               res_in.result_value = {1'b1, {(W-1){1'b0}}};
            end else begin
               res_in.result_value = sum[W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= sti_pkg::COUNT_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      q_ff        <= q_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      t_lo_ff     <= t_lo_in;
      v_lo_ff     <= v_lo_in;
      t_hi_ff     <= t_hi_in;
      v_hi_ff     <= v_hi_in;
      mv_ff       <= mv_in;
      mq_ff       <= mq_in;
      mt_ff       <= mt_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sorted_table_interpolating_lookup_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_interpolating_lookup_unit_tb
// Self-checking bench for the sorted table interpolating lookup unit. Loads
// the whole table, runs directed lookups at the table and count extremes,
// holds off responses to back the unit up, then runs phases of random
// lookups and table rewrites under several entry counts. Every response is
// checked against an in-bench lookup predictor.
// ----------------------------------------------------------------------------
module sorted_table_interpolating_lookup_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   sti_pkg::req_type             req_data    = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   sti_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en   = 1'b0;
   logic [sti_pkg::COUNT_W-1:0]  csr_wr_data = '0;

   logic [sti_pkg::WORD_W-1:0]        table_time  [sti_pkg::TABLE_DEPTH];
   logic signed [sti_pkg::WORD_W-1:0] table_value [sti_pkg::TABLE_DEPTH];
   logic [sti_pkg::COUNT_W-1:0]       entry_count = 11'd2;
   sti_pkg::rsp_type                  awaited_lookups [$];
   int                                mismatch_count = 0;
   bit                                gaps_on = 1'b1;
   bit                                holding = 1'b0;
   int                                stall_run = 0;
   event                              hold_off_start;

   sorted_table_interpolating_lookup_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int active_entries();
      int n;
      n = int'(entry_count);
      if (n < 2) n = 2;
      if (n > sti_pkg::TABLE_DEPTH) n = sti_pkg::TABLE_DEPTH;
      return n;
   endfunction

   function automatic logic signed [sti_pkg::WORD_W-1:0] interpolated_value(
      int lo, int hi, logic [sti_pkg::WORD_W-1:0] q);
      longint      v0, dv, dq, dt, inc, r;
      logic [63:0] mv, mq, mt, mag;
      logic        neg;
      v0 = longint'(table_value[lo]);
      dv = longint'(table_value[hi]) - v0;
      dq = longint'(q) - longint'(table_time[lo]);
      dt = longint'(table_time[hi]) - longint'(table_time[lo]);
      if (dt == 0) return table_value[lo];
      mv = (dv < 0) ? -dv : dv;
      mq = (dq < 0) ? -dq : dq;
      mt = (dt < 0) ? -dt : dt;
      mag = (mv * mq) / mt;
      if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
      neg = ((dv < 0) != (dq < 0)) != (dt < 0);
      inc = neg ? -longint'(mag) : longint'(mag);
      r = v0 + inc;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[sti_pkg::WORD_W-1:0];
   endfunction

   function automatic sti_pkg::rsp_type expected_lookup(sti_pkg::req_type item);
      sti_pkg::rsp_type           res;
      int                         lo, hi, mid;
      logic [sti_pkg::WORD_W-1:0] q;
      res = '{status: sti_pkg::STATUS_LOADED, result_value: '0};
      if (item.kind == sti_pkg::KIND_LOAD) begin
         table_time[item.entry_index]  = item.entry_time;
         table_value[item.entry_index] = item.entry_value;
         return res;
      end
      q = item.query_time;
      lo = 0;
      hi = active_entries() - 1;
      if (q < table_time[lo] || q > table_time[hi]) begin
         res.status = sti_pkg::STATUS_RANGE;
         return res;
      end
      res.status = sti_pkg::STATUS_VALUE;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (table_time[mid] == q) begin
            res.result_value = table_value[mid];
            return res;
         end
         if (table_time[mid] > q) hi = mid;
         else lo = mid;
      end
      if (table_time[lo] == q) res.result_value = table_value[lo];
      else if (table_time[hi] == q) res.result_value = table_value[hi];
      else res.result_value = interpolated_value(lo, hi, q);
      return res;
   endfunction

   task automatic note_mismatch(string what, sti_pkg::rsp_type want, sti_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t mismatch (%s): expected status %0d value %0d, got status %0d value %0d",
                  $time, what, want.status, want.result_value, got.status, got.result_value);
      end
   endtask

   always @(negedge clock) begin
      sti_pkg::rsp_type want;
      if (!reset) begin
         if (csr_wr_en) entry_count = csr_wr_data;
         if (req_valid && !req_stall) awaited_lookups.push_back(expected_lookup(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_lookups.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_data);
            end else begin
               want = awaited_lookups.pop_front();
               if (rsp_data.status !== want.status)
                  note_mismatch("status", want, rsp_data);
               else if (rsp_data.result_value !== want.result_value)
                  note_mismatch("result_value", want, rsp_data);
            end
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (holding) begin
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (gaps_on && $urandom_range(0, 99) < 25) begin
         stall_run = pick_gap() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always begin
      @(hold_off_start);
      @(negedge clock);
      holding = 1'b1;
      repeat (600) @(negedge clock);
      holding = 1'b0;
   end

   task automatic send_request(input sti_pkg::req_type item);
      int gap;
      bit taken;
      gap = (gaps_on && $urandom_range(0, 99) >= 65) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_load(input logic [sti_pkg::INDEX_W-1:0] index,
                            input logic [sti_pkg::WORD_W-1:0] t,
                            input logic [sti_pkg::WORD_W-1:0] v);
      sti_pkg::req_type item;
      item = '{kind: sti_pkg::KIND_LOAD, entry_index: index, entry_time: t, entry_value: v,
               query_time: $urandom()};
      send_request(item);
   endtask

   task automatic send_query(input logic [sti_pkg::WORD_W-1:0] q);
      sti_pkg::req_type item;
      item = '{kind: sti_pkg::KIND_QUERY,
               entry_index: sti_pkg::INDEX_W'($urandom_range(0, sti_pkg::TABLE_DEPTH - 1)),
               entry_time: $urandom(), entry_value: $urandom(), query_time: q};
      send_request(item);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (awaited_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [sti_pkg::COUNT_W-1:0] value);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [sti_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [sti_pkg::WORD_W-1:0] pick_query_time(int n);
      logic [sti_pkg::WORD_W-1:0] first, last, pt;
      int                         sel;
      first = table_time[0];
      last  = table_time[n - 1];
      pt    = table_time[$urandom_range(0, n - 1)];
      sel   = $urandom_range(0, 99);
      if (sel < 40 && first <= last) return first + $urandom_range(0, last - first);
      if (sel < 70) return pt;
      if (sel < 80) return $urandom_range(0, 1) ? pt + 32'd1 : pt - 32'd1;
      if (sel < 90) begin
         if (first != 0 && $urandom_range(0, 1)) return $urandom_range(0, first - 1);
         if (last != 32'hFFFF_FFFF) return last + 32'd1 + $urandom_range(0, ~last - 32'd1);
      end
      return $urandom();
   endfunction

   // rewrite entries 0..count-1 in ascending order, staying at or below top
   task automatic refill_prefix(input int count, input logic [sti_pkg::WORD_W-1:0] top,
                                input logic [sti_pkg::WORD_W-1:0] stride_limit);
      logic [sti_pkg::WORD_W-1:0] base, cap, t;
      base = $urandom_range(0, top >> 1);
      cap  = (top - base) / count;
      if (cap > stride_limit) cap = stride_limit;
      t = base;
      for (int k = 0; k < count; k++) begin
         send_load(sti_pkg::INDEX_W'(k), t, pick_value());
         t = t + $urandom_range(0, cap);
      end
   endtask

   // keep the table sorted most of the time, scramble it now and then
   task automatic rewrite_entry(input int n);
      logic [sti_pkg::WORD_W-1:0] lo_b, hi_b, swap;
      int                         i;
      if ($urandom_range(0, 7) == 0) begin
         send_load(sti_pkg::INDEX_W'($urandom_range(0, sti_pkg::TABLE_DEPTH - 1)),
                   $urandom(), pick_value());
      end else begin
         i    = $urandom_range(0, n - 1);
         lo_b = (i > 0) ? table_time[i - 1] : 32'h0;
         hi_b = (i < n - 1) ? table_time[i + 1] : 32'hFFFF_FFFF;
         if (lo_b > hi_b) begin
            swap = lo_b;
            lo_b = hi_b;
            hi_b = swap;
         end
         send_load(sti_pkg::INDEX_W'(i), lo_b + $urandom_range(0, hi_b - lo_b), pick_value());
      end
   endtask

   task automatic test_fill_table();
      refill_prefix(sti_pkg::TABLE_DEPTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed_lookups();
      write_entry_count(11'd2047);
      send_query(table_time[0]);
      send_query(table_time[sti_pkg::TABLE_DEPTH - 1]);
      send_query(table_time[511]);
      send_query(table_time[300] + ((table_time[301] - table_time[300]) >> 1));
      if (table_time[0] != 32'h0) send_query(table_time[0] - 32'd1);
      if (table_time[sti_pkg::TABLE_DEPTH - 1] != 32'hFFFF_FFFF)
         send_query(table_time[sti_pkg::TABLE_DEPTH - 1] + 32'd1);
      write_entry_count(11'd1025);
      send_query(table_time[sti_pkg::TABLE_DEPTH - 1]);

      send_load(10'd0, 32'h0000_0000, 32'h8000_0000);
      send_load(10'd1, 32'h0001_0000, 32'h7FFF_FFFF);
      send_load(10'd2, 32'h7FFF_FFFF, 32'h0000_0000);
      send_load(10'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_entry_count(11'd0);
      send_query(32'h0000_0000);
      send_query(32'h0000_8000);
      send_query(32'hFFFF_FFFF);
      write_entry_count(11'd1);
      send_query(32'h0001_0000);
      write_entry_count(11'd4);
      send_query(32'hFFFF_FFFF);
      send_query(32'h8000_0000);
      send_query(32'h7FFF_FFFF);
      send_query(32'h0000_0001);

      // restore the low entries below the rest of the table
      refill_prefix(4, table_time[4], 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      write_entry_count(11'd256);
      gaps_on = 1'b0;
      -> hold_off_start;
      repeat (40) send_query(pick_query_time(active_entries()));
      wait_until_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int                         count_choices [6] = '{0, 1, 2, 2047, 1024, 1025};
      int                         cfg, n;
      logic [sti_pkg::WORD_W-1:0] stride_limit;
      for (int phase = 0; phase < 14; phase++) begin
         if (phase < 6) begin
            cfg = count_choices[phase];
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: cfg = $urandom_range(2, 64);
               5, 6, 7:       cfg = $urandom_range(65, 1024);
               default:       cfg = $urandom_range(0, 2047);
            endcase
         end
         write_entry_count(cfg[sti_pkg::COUNT_W-1:0]);
         gaps_on = (phase % 4 != 3);
         n = active_entries();
         if (n <= 64 && $urandom_range(0, 1)) begin
            case ($urandom_range(0, 2))
               0:       stride_limit = 32'd3;
               1:       stride_limit = 32'd4096;
               default: stride_limit = 32'hFFFF_FFFF;
            endcase
            refill_prefix(n, table_time[n], stride_limit);
         end
         repeat (30) begin
            if ($urandom_range(0, 99) < 85) send_query(pick_query_time(n));
            else rewrite_entry(n);
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_table();
      test_directed_lookups();
      test_backpressure();
      test_random_traffic();
      wait_until_idle();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && awaited_lookups.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
